// ----- sv/lzt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and defaults for the LZ77 match tokenizer.
// No dependencies; every other file of the block imports this package.
package lzt_pkg;

  localparam int WINDOW_MAX_DEF    = 256;
  localparam int LOOKAHEAD_MAX_DEF = 32;
  localparam int RING_DEPTH_DEF    = 512;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD_SIZE = 8'd1;

  localparam logic [8:0] WINDOW_RESET    = 9'd256;
  localparam logic [5:0] LOOKAHEAD_RESET = 6'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // store the incoming byte
    logic start;     // open a token decision at the cursor
    logic cap_head;  // latch the byte at the cursor
    logic compare;   // act on one byte comparison
    logic finish;    // load the token and advance the cursor
  } lzt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic token_due;  // enough bytes are held to decide a token
    logic cand;       // at least one candidate start exists
    logic extend;     // the current candidate grows by one byte
    logic more;       // another candidate follows the current one
  } lzt_stat_t;

endpackage

// ----- sv/lzt_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the tokenizer: input bytes, tokens and register writes.
// Depends on lzt_pkg.
interface lzt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface lzt_tok_if;
  logic       valid;
  logic       ready;
  logic       is_match;
  logic [7:0] match_offset;
  logic [4:0] match_length;
  logic [7:0] literal_byte;
  logic       last_token;
  modport source (output valid, is_match, match_offset, match_length, literal_byte,
                  last_token, input ready);
  modport sink (input valid, is_match, match_offset, match_length, literal_byte,
                last_token, output ready);
endinterface

interface lzt_cfg_if;
  import lzt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/lzt_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the tokenizer.
// Depends on lzt_pkg; drives the commands of lzt_datapath.
module lzt_ctrl
  import lzt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lzt_stat_t stat,
  output lzt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_HEAD_RD, ST_HEAD_CAP, ST_SCAN_RD, ST_SCAN_CMP, ST_RESULT, ST_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && in_ready;
    cmd.start    = (state == ST_DECIDE) && stat.token_due;
    cmd.cap_head = (state == ST_HEAD_CAP);
    cmd.compare  = (state == ST_SCAN_CMP);
    cmd.finish   = (state == ST_RESULT);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE:   state_next = stat.token_due ? ST_HEAD_RD : ST_IDLE;
      ST_HEAD_RD:  state_next = ST_HEAD_CAP;
      ST_HEAD_CAP: state_next = stat.cand ? ST_SCAN_RD : ST_RESULT;
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: state_next = (stat.extend || stat.more) ? ST_SCAN_RD : ST_RESULT;
      ST_RESULT:   state_next = ST_EMIT;
      ST_EMIT:     if (out_ready) state_next = ST_DECIDE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == ST_IDLE);
      out_valid <= (state_next == ST_EMIT);
    end
  end

endmodule

// ----- sv/lzt_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the tokenizer: byte ring, positions, candidate scan and token register.
// Depends on lzt_pkg; steered by lzt_ctrl.
module lzt_datapath
  import lzt_pkg::*;
#(
  parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
  parameter int LOOKAHEAD_MAX = LOOKAHEAD_MAX_DEF,
  parameter int RING_DEPTH    = RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lzt_cmd_t                         cmd,
  output lzt_stat_t                        stat,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  input  logic [$clog2(WINDOW_MAX)-1:0]    win_m1,
  input  logic [$clog2(LOOKAHEAD_MAX)-1:0] maxlen,
  output logic                             is_match,
  output logic [7:0]                       match_offset,
  output logic [4:0]                       match_length,
  output logic [7:0]                       literal_byte,
  output logic                             last_token
);

  localparam int DW = $clog2(WINDOW_MAX);
  localparam int LW = $clog2(LOOKAHEAD_MAX);
  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW:0] DEPTH = (AW+1)'(RING_DEPTH);

  logic [7:0]    ring [RING_DEPTH];
  logic [7:0]    rd_a, rd_b;
  logic [31:0]   cursor, received;
  logic [AW-1:0] cur_idx, wr_idx;
  logic          end_seen;
  logic [DW-1:0] back_dist, best_d;
  logic [LW-1:0] len, best_len;
  logic [7:0]    head;

  logic [31:0]   pending, cursor_next;
  logic [AW:0]   back_sum, back_red, a_sum, b_sum, adv_sum;
  logic [AW-1:0] addr_a, addr_b, wr_next, cur_idx_next;
  logic          in_range;

  assign pending = received - cursor;

  // Ring positions wrap at the ring depth; each sum stays below twice the depth.
  always_comb begin
    back_sum = {1'b0, cur_idx} + DEPTH - (AW+1)'(back_dist);
    back_red = (back_sum >= DEPTH) ? back_sum - DEPTH : back_sum;
    a_sum    = back_red + (AW+1)'(len);
    addr_a   = (a_sum >= DEPTH) ? AW'(a_sum - DEPTH) : AW'(a_sum);
    b_sum    = {1'b0, cur_idx} + (AW+1)'(len);
    addr_b   = (b_sum >= DEPTH) ? AW'(b_sum - DEPTH) : AW'(b_sum);
    wr_next  = ({1'b0, wr_idx} + 1'b1 >= DEPTH) ? '0 : wr_idx + 1'b1;
  end

  always_comb begin
    if (best_len > LW'(1)) begin
      cursor_next = cursor + 32'(best_len);
      adv_sum     = {1'b0, cur_idx} + (AW+1)'(best_len);
    end else begin
      cursor_next = cursor + 32'd1;
      adv_sum     = {1'b0, cur_idx} + 1'b1;
    end
    cur_idx_next = (adv_sum >= DEPTH) ? AW'(adv_sum - DEPTH) : AW'(adv_sum);
  end

  assign in_range = (len == '0) ||
                    ((len < maxlen) && (32'(len) < 32'(back_dist)) && (32'(len) < pending));

  assign stat.token_due = (pending != '0) && (end_seen || (pending >= 32'(maxlen)));
  assign stat.cand      = (back_dist >= DW'(2));
  assign stat.extend    = in_range && (rd_a == rd_b);
  assign stat.more      = (back_dist > DW'(2));

  always_ff @(posedge clk) begin
    rd_a <= ring[addr_a];
    rd_b <= ring[addr_b];
    if (cmd.accept) ring[end_seen ? '0 : wr_idx] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      received <= '0;
      cur_idx  <= '0;
      wr_idx   <= '0;
      end_seen <= 1'b0;
    end else if (cmd.accept) begin
      // A byte after the end of a string opens a new one.
      if (end_seen) begin
        cursor   <= '0;
        received <= 32'd1;
        cur_idx  <= '0;
        wr_idx   <= (DEPTH > (AW+1)'(1)) ? AW'(1) : '0;
      end else begin
        received <= received + 32'd1;
        wr_idx   <= wr_next;
      end
      end_seen <= last_byte;
    end else if (cmd.finish) begin
      cursor  <= cursor_next;
      cur_idx <= cur_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      back_dist <= (cursor >= 32'(win_m1)) ? win_m1 : DW'(cursor);
      len       <= '0;
      best_len  <= LW'(1);
      best_d    <= '0;
    end else if (cmd.cap_head) begin
      head <= rd_b;
    end else if (cmd.compare) begin
      if (stat.extend) begin
        len <= len + 1'b1;
      end else begin
        if (len > best_len) begin
          best_len <= len;
          best_d   <= back_dist;
        end
        len       <= '0;
        back_dist <= back_dist - 1'b1;
      end
    end
    if (cmd.finish) begin
      is_match     <= (best_len > LW'(1));
      match_offset <= (best_len > LW'(1)) ? 8'(best_d) : 8'd0;
      match_length <= (best_len > LW'(1)) ? 5'(best_len) : 5'd0;
      literal_byte <= (best_len > LW'(1)) ? 8'd0 : head;
      last_token   <= end_seen && (cursor_next == received);
    end
  end

endmodule

// ----- sv/lz77_match_tokenizer_core.sv -----
`timescale 1ns / 1ps
// Top level of the LZ77 match tokenizer: register file, controller and datapath.
// Depends on lzt_pkg, the interfaces in lzt_if.sv, lzt_ctrl and lzt_datapath.
//
//   Channel   Kind     Carries
//   byte_ch   sink     data_byte, last_byte (one request per input byte)
//   token_ch  source   is_match, match_offset, match_length, literal_byte, last_token
//   cfg_ch    sink     index, data (0 = window_size, 1 = lookahead_size)
//
// One byte is taken at a time. After it the block decides every token that has
// become due; each token passes the decide, head read, head capture, result and
// emit states, plus a read and a compare state per byte comparison, since every
// comparison goes through the single pair of read ports of the byte ring.
// Reset is synchronous and active high; it clears the positions and the end flag,
// while the ring itself needs no clearing. A stalled token holds the block.
module lz77_match_tokenizer_core
  import lzt_pkg::*;
#(
  parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
  parameter int LOOKAHEAD_MAX = LOOKAHEAD_MAX_DEF,
  parameter int RING_DEPTH    = RING_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  lzt_byte_if.sink   byte_ch,
  lzt_tok_if.source  token_ch,
  lzt_cfg_if.sink    cfg_ch
);

  localparam int DW = $clog2(WINDOW_MAX);
  localparam int LW = $clog2(LOOKAHEAD_MAX);

  logic [8:0]    window_size;
  logic [5:0]    lookahead_size;
  logic [31:0]   win_clamp, look_clamp;
  logic [DW-1:0] win_m1;
  logic [LW-1:0] maxlen;
  lzt_cmd_t      cmd;
  lzt_stat_t     stat;

  // Register writes are always taken; the user keeps them to idle times, unenforced by the block.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= WINDOW_RESET;
      lookahead_size <= LOOKAHEAD_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_WINDOW_SIZE:    window_size    <= cfg_ch.data[8:0];
        REG_LOOKAHEAD_SIZE: lookahead_size <= cfg_ch.data[5:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped to what the hardware supports.
  always_comb begin
    win_clamp  = 32'(window_size);
    look_clamp = 32'(lookahead_size);
    if (win_clamp < 32'd2) win_clamp = 32'd2;
    if (win_clamp > 32'(WINDOW_MAX)) win_clamp = 32'(WINDOW_MAX);
    if (look_clamp < 32'd2) look_clamp = 32'd2;
    if (look_clamp > 32'(LOOKAHEAD_MAX)) look_clamp = 32'(LOOKAHEAD_MAX);
    win_m1 = DW'(win_clamp - 32'd1);
    maxlen = LW'(look_clamp - 32'd1);
  end

  lzt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_ch.valid),
    .in_ready  (byte_ch.ready),
    .out_valid (token_ch.valid),
    .out_ready (token_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lzt_datapath #(
    .WINDOW_MAX    (WINDOW_MAX),
    .LOOKAHEAD_MAX (LOOKAHEAD_MAX),
    .RING_DEPTH    (RING_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .data_byte    (byte_ch.data_byte),
    .last_byte    (byte_ch.last_byte),
    .win_m1       (win_m1),
    .maxlen       (maxlen),
    .is_match     (token_ch.is_match),
    .match_offset (token_ch.match_offset),
    .match_length (token_ch.match_length),
    .literal_byte (token_ch.literal_byte),
    .last_token   (token_ch.last_token)
  );

  // A pending token keeps the byte channel closed.
  a_token_blocks_bytes: assert property (@(posedge clk) disable iff (rst)
    token_ch.valid |-> !byte_ch.ready)
    else $error("byte channel open while a token waits");

  // Each accepted byte is followed by decision work, during which the byte channel stays closed.
  a_byte_closes_input: assert property (@(posedge clk) disable iff (rst)
    (byte_ch.valid && byte_ch.ready) |=> !byte_ch.ready)
    else $error("byte channel stayed open after a request");

  // A match token carries no literal; a literal token carries no offset or length.
  a_match_fields: assert property (@(posedge clk) disable iff (rst)
    (token_ch.valid && token_ch.is_match) |-> (token_ch.literal_byte == 8'd0))
    else $error("match token with a literal byte");

  a_literal_fields: assert property (@(posedge clk) disable iff (rst)
    (token_ch.valid && !token_ch.is_match) |->
      (token_ch.match_offset == 8'd0 && token_ch.match_length == 5'd0))
    else $error("literal token with offset or length");

endmodule
